>>> design/drl_pkg.sv
`default_nettype none

package drl_pkg;

    // Capacity of the rectangle list
    localparam int MAX_RECTS = 16;

    // Count holds 0..MAX_RECTS, index addresses 0..MAX_RECTS-1
    localparam int CNT_W = $clog2(MAX_RECTS + 1);
    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    localparam int POS_W   = 13;
    localparam int LEN_W   = 14;
    localparam int IN_W    = 16;
    localparam int CFG_W   = 14;
    localparam int ENTRY_W = 7;

    localparam logic [LEN_W-1:0] SCREEN_MAX = LEN_W'(8192);

    // Item kinds
    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_CLEAR    = 2'd1;
    localparam logic [1:0] KIND_MARK_ALL = 2'd2;
    localparam logic [1:0] KIND_READ     = 2'd3;

    // Configuration register indexes
    localparam logic REG_SCREEN_W = 1'b0;
    localparam logic REG_SCREEN_H = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [LEN_W-1:0] w;
        logic [LEN_W-1:0] h;
    } t_rect;

endpackage

`default_nettype wire

>>> design/damage_rect_list.sv
`default_nettype none
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+---------------------------------------
// in        | to block  | i_in_valid / o_in_stall  | i_kind, i_rect_x/y/w/h
// out       | from block| o_out_valid / i_out_stall| o_found, o_out_x/y/w/h, o_entry_count
// cfg       | to block  | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
// Steps: add runs clip x, clip y, then a scan over the stored entries (up to the count,
//   at most MAX_RECTS), one per cycle through a single overlap compare unit fed by the
//   registered read port of the rectangle memory, then merge or append, then reply. A
//   dropped add goes from clip y to reply, clear and mark-all go straight to reply, read-next via read.
// One item at a time: o_in_stall is high from acceptance until the beat is put into the
//   output register; a finished beat may wait there while the next item is taken.
// Reset clears count, read pointer, state and output valid at once; the memory is not
//   cleared, since entries at or above the count are never read.
// A stalled output beat holds until taken; the sequencer waits in its reply step.

module damage_rect_list (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input items
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_kind,
    input  wire  signed [drl_pkg::IN_W-1:0] i_rect_x,
    input  wire  signed [drl_pkg::IN_W-1:0] i_rect_y,
    input  wire  signed [drl_pkg::IN_W-1:0] i_rect_w,
    input  wire  signed [drl_pkg::IN_W-1:0] i_rect_h,
    // results
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_found,
    output logic [drl_pkg::POS_W-1:0]      o_out_x,
    output logic [drl_pkg::POS_W-1:0]      o_out_y,
    output logic [drl_pkg::LEN_W-1:0]      o_out_w,
    output logic [drl_pkg::LEN_W-1:0]      o_out_h,
    output logic [drl_pkg::ENTRY_W-1:0]    o_entry_count,
    // configuration
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_idx,
    input  wire  [drl_pkg::CFG_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP_X,
        ST_CLIP_Y,
        ST_SCAN,
        ST_MERGE,
        ST_APPEND,
        ST_READ,
        ST_REPLY
    } t_state;

    t_state                         r_state;
    logic [drl_pkg::LEN_W-1:0]      r_scr_w;
    logic [drl_pkg::LEN_W-1:0]      r_scr_h;
    logic [drl_pkg::CNT_W-1:0]      r_count;
    logic [drl_pkg::CNT_W-1:0]      r_rptr;
    logic [drl_pkg::CNT_W-1:0]      r_idx;

    logic signed [drl_pkg::IN_W-1:0] r_in_x;
    logic signed [drl_pkg::IN_W-1:0] r_in_y;
    logic signed [drl_pkg::IN_W-1:0] r_in_w;
    logic signed [drl_pkg::IN_W-1:0] r_in_h;
    drl_pkg::t_rect                 r_new;
    logic                           r_ok_x;

    logic                           r_res_found;
    drl_pkg::t_rect                 r_res_rect;

    logic                           r_out_valid;
    logic                           r_out_found;
    drl_pkg::t_rect                 r_out_rect;
    logic [drl_pkg::ENTRY_W-1:0]    r_out_cnt;

    drl_pkg::t_rect                 r_mem [drl_pkg::MAX_RECTS];
    drl_pkg::t_rect                 r_mem_q;

    logic                           in_acc;
    logic [drl_pkg::LEN_W-1:0]      eff_w;
    logic [drl_pkg::LEN_W-1:0]      eff_h;
    drl_pkg::t_rect                 full_rect;
    logic [drl_pkg::CNT_W-1:0]      idx_inc;

    // shared clip unit
    logic signed [drl_pkg::IN_W-1:0] cu_pos;
    logic signed [drl_pkg::IN_W-1:0] cu_len;
    logic [drl_pkg::LEN_W-1:0]      cu_dim;
    logic signed [18:0]             cu_p0;
    logic signed [18:0]             cu_l0;
    logic signed [18:0]             cu_e0;
    logic signed [18:0]             cu_d;
    logic signed [18:0]             cu_l1;
    logic                           cu_ok;

    // overlap compare and union
    logic [drl_pkg::LEN_W-1:0]      nx1;
    logic [drl_pkg::LEN_W-1:0]      ny1;
    logic [drl_pkg::LEN_W-1:0]      rx1;
    logic [drl_pkg::LEN_W-1:0]      ry1;
    logic                           overlap;
    logic [drl_pkg::POS_W-1:0]      ux;
    logic [drl_pkg::POS_W-1:0]      uy;
    logic [drl_pkg::LEN_W-1:0]      ux2;
    logic [drl_pkg::LEN_W-1:0]      uy2;
    drl_pkg::t_rect                 union_rect;

    // memory ports
    logic                           mem_we;
    logic [drl_pkg::IDX_W-1:0]      mem_wa;
    drl_pkg::t_rect                 mem_wd;
    logic [drl_pkg::IDX_W-1:0]      rd_addr;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // Screen size: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (r_scr_w == '0) begin
            eff_w = drl_pkg::LEN_W'(1);
        end else if (r_scr_w > drl_pkg::SCREEN_MAX) begin
            eff_w = drl_pkg::SCREEN_MAX;
        end else begin
            eff_w = r_scr_w;
        end
        if (r_scr_h == '0) begin
            eff_h = drl_pkg::LEN_W'(1);
        end else if (r_scr_h > drl_pkg::SCREEN_MAX) begin
            eff_h = drl_pkg::SCREEN_MAX;
        end else begin
            eff_h = r_scr_h;
        end
        full_rect.x = '0;
        full_rect.y = '0;
        full_rect.w = eff_w;
        full_rect.h = eff_h;
    end

    assign idx_inc = r_idx + 1'b1;

    // Clip one axis per cycle: x in the first clip step, y in the second.
    // Negative start eats into the length; a far edge past the screen is cut back.
    always_comb begin
        if (r_state == ST_CLIP_X) begin
            cu_pos = r_in_x;
            cu_len = r_in_w;
            cu_dim = eff_w;
        end else begin
            cu_pos = r_in_y;
            cu_len = r_in_h;
            cu_dim = eff_h;
        end
        cu_p0 = cu_pos[drl_pkg::IN_W-1] ? 19'sd0 : {{3{cu_pos[drl_pkg::IN_W-1]}}, cu_pos};
        cu_l0 = {{3{cu_len[drl_pkg::IN_W-1]}}, cu_len};
        if (cu_pos[drl_pkg::IN_W-1]) begin
            cu_l0 = cu_l0 + {{3{cu_pos[drl_pkg::IN_W-1]}}, cu_pos};
        end
        cu_e0 = cu_p0 + cu_l0;
        cu_d  = {5'b0, cu_dim};
        cu_l1 = (cu_e0 > cu_d) ? (cu_d - cu_p0) : cu_l0;
        cu_ok = !cu_l1[18] && (cu_l1 != 19'sd0);
    end

    // Strict overlap of the new rectangle against the entry on the read port;
    // touching edges do not count
    always_comb begin
        nx1 = {1'b0, r_new.x} + r_new.w;
        ny1 = {1'b0, r_new.y} + r_new.h;
        rx1 = {1'b0, r_mem_q.x} + r_mem_q.w;
        ry1 = {1'b0, r_mem_q.y} + r_mem_q.h;
        overlap = !((nx1 <= {1'b0, r_mem_q.x}) || ({1'b0, r_new.x} >= rx1) ||
                    (ny1 <= {1'b0, r_mem_q.y}) || ({1'b0, r_new.y} >= ry1));
        ux  = (r_new.x < r_mem_q.x) ? r_new.x : r_mem_q.x;
        uy  = (r_new.y < r_mem_q.y) ? r_new.y : r_mem_q.y;
        ux2 = (nx1 > rx1) ? nx1 : rx1;
        uy2 = (ny1 > ry1) ? ny1 : ry1;
        union_rect.x = ux;
        union_rect.y = uy;
        union_rect.w = ux2 - {1'b0, ux};
        union_rect.h = uy2 - {1'b0, uy};
    end

    // Read address: prefetch the next entry while scanning, hold on a hit
    always_comb begin
        case (r_state)
            ST_IDLE:   rd_addr = r_rptr[drl_pkg::IDX_W-1:0];
            ST_CLIP_X: rd_addr = '0;
            ST_CLIP_Y: rd_addr = '0;
            ST_SCAN:   rd_addr = overlap ? r_idx[drl_pkg::IDX_W-1:0]
                                         : idx_inc[drl_pkg::IDX_W-1:0];
            default:   rd_addr = r_idx[drl_pkg::IDX_W-1:0];
        endcase
    end

    // Write port: mark-all on acceptance, merge on a hit, append or collapse at the end
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = full_rect;
        case (r_state)
            ST_IDLE: begin
                mem_we = in_acc && (i_kind == drl_pkg::KIND_MARK_ALL);
            end
            ST_MERGE: begin
                mem_we = 1'b1;
                mem_wa = r_idx[drl_pkg::IDX_W-1:0];
                mem_wd = union_rect;
            end
            ST_APPEND: begin
                mem_we = 1'b1;
                if (r_count < drl_pkg::CNT_W'(drl_pkg::MAX_RECTS)) begin
                    mem_wa = r_count[drl_pkg::IDX_W-1:0];
                    mem_wd = r_new;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scr_w     <= drl_pkg::LEN_W'(1024);
            r_scr_h     <= drl_pkg::LEN_W'(768);
            r_count     <= '0;
            r_rptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    drl_pkg::REG_SCREEN_W: r_scr_w <= i_cfg_data;
                    drl_pkg::REG_SCREEN_H: r_scr_h <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the output beat once taken; the reply step reloads it itself
            if (r_out_valid && !i_out_stall && (r_state != ST_REPLY)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_in_x      <= i_rect_x;
                        r_in_y      <= i_rect_y;
                        r_in_w      <= i_rect_w;
                        r_in_h      <= i_rect_h;
                        r_res_found <= 1'b0;
                        r_res_rect  <= '0;
                        case (i_kind)
                            drl_pkg::KIND_ADD: begin
                                r_state <= ST_CLIP_X;
                            end
                            drl_pkg::KIND_CLEAR: begin
                                r_count <= '0;
                                r_state <= ST_REPLY;
                            end
                            drl_pkg::KIND_MARK_ALL: begin
                                r_count <= drl_pkg::CNT_W'(1);
                                r_state <= ST_REPLY;
                            end
                            drl_pkg::KIND_READ: begin
                                r_state <= ST_READ;
                            end
                            default: begin
                                r_state <= ST_REPLY;
                            end
                        endcase
                    end
                end
                ST_CLIP_X: begin
                    r_new.x <= cu_p0[drl_pkg::POS_W-1:0];
                    r_new.w <= cu_l1[drl_pkg::LEN_W-1:0];
                    r_ok_x  <= cu_ok;
                    r_state <= ST_CLIP_Y;
                end
                ST_CLIP_Y: begin
                    r_new.y <= cu_p0[drl_pkg::POS_W-1:0];
                    r_new.h <= cu_l1[drl_pkg::LEN_W-1:0];
                    r_idx   <= '0;
                    if (!(r_ok_x && cu_ok)) begin
                        r_state <= ST_REPLY;
                    end else if (r_count == '0) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (overlap) begin
                        r_state <= ST_MERGE;
                    end else if (idx_inc >= r_count) begin
                        r_state <= ST_APPEND;
                    end else begin
                        r_idx <= idx_inc;
                    end
                end
                ST_MERGE: begin
                    r_state <= ST_REPLY;
                end
                ST_APPEND: begin
                    // a full list collapses into one full-screen entry
                    if (r_count < drl_pkg::CNT_W'(drl_pkg::MAX_RECTS)) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_count <= drl_pkg::CNT_W'(1);
                    end
                    r_state <= ST_REPLY;
                end
                ST_READ: begin
                    if (r_rptr >= r_count) begin
                        r_rptr <= '0;
                    end else begin
                        r_res_found <= 1'b1;
                        r_res_rect  <= r_mem_q;
                        r_rptr      <= r_rptr + 1'b1;
                    end
                    r_state <= ST_REPLY;
                end
                ST_REPLY: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_rect  <= r_res_rect;
                        r_out_cnt   <= drl_pkg::ENTRY_W'(r_count);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_out_x       = r_out_rect.x;
    assign o_out_y       = r_out_rect.y;
    assign o_out_w       = r_out_rect.w;
    assign o_out_h       = r_out_rect.h;
    assign o_entry_count = r_out_cnt;

endmodule

`default_nettype wire

>>> design/drl_chk.sv
`default_nettype none

module drl_chk (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             o_in_stall,
    input wire                             o_out_valid,
    input wire                             i_out_stall,
    input wire                             o_found,
    input wire  [drl_pkg::POS_W-1:0]       o_out_x,
    input wire  [drl_pkg::POS_W-1:0]       o_out_y,
    input wire  [drl_pkg::LEN_W-1:0]       o_out_w,
    input wire  [drl_pkg::LEN_W-1:0]       o_out_h,
    input wire  [drl_pkg::ENTRY_W-1:0]     o_entry_count
);

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    // a miss or a non-read beat carries an all-zero rectangle
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |->
            (o_out_x == '0) && (o_out_y == '0) && (o_out_w == '0) && (o_out_h == '0))
        else $error("rectangle fields nonzero without found");

    // a returned rectangle is nonempty and comes from a nonempty list
    a_hit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |->
            (o_out_w != '0) && (o_out_h != '0) && (o_entry_count != '0))
        else $error("found beat with empty rectangle or empty list");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= drl_pkg::ENTRY_W'(drl_pkg::MAX_RECTS)))
        else $error("entry count above capacity");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_found) && $stable(o_out_x) && $stable(o_out_w)
            && $stable(o_entry_count))
        else $error("stalled output beat changed");

endmodule

bind damage_rect_list drl_chk u_drl_chk (.*);

`default_nettype wire
